FILE: rtl/core/trace_envelope_normalizer_macros.svh
// Assertion macros for the trace envelope normalizer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TRACE_ENVELOPE_NORMALIZER_MACROS_SVH
`define TRACE_ENVELOPE_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: post must hold whenever pre holds.
`define TEN_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> post) \
        else $error("trace envelope normalizer: check failed");
// Next-cycle implication: post must hold in the cycle after pre.
`define TEN_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("trace envelope normalizer: check failed");
`else
`define TEN_ASSERT_IMP(name, clk, rst_n, pre, post)
`define TEN_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

FILE: rtl/core/tenv_pkg.sv
// Shared constants, control structs and the divide-by-five reciprocal
// for the trace envelope normalizer. No dependencies.
`timescale 1ns / 1ps

package tenv_pkg;

    // Formats
    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int INT_BITS    = 16;
    localparam int ENV_BITS    = INT_BITS + FRAC_BITS;
    localparam int FLOOR_BITS  = INT_BITS;
    localparam int OUT_BITS    = 15;
    localparam int LANES       = 4;

    localparam logic [OUT_BITS-1:0]   OUT_MAX     = '1;
    localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = FLOOR_BITS'(200);

    // Envelope step: attack is gap/20 = (gap/4)/5, decay is gap/10 = (gap/2)/5
    localparam int ATTACK_SHIFT = 2;
    localparam int DECAY_SHIFT  = 1;
    localparam int OP_BITS      = ENV_BITS - 1;
    localparam int DIV5_SHIFT   = OP_BITS + 2;
    localparam int Q_BITS       = 2 * OP_BITS - DIV5_SHIFT;
    localparam logic [OP_BITS-1:0] DIV5_MULT =
        OP_BITS'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

    // Channel scaling: sample * 2000 * 2^FRAC_BITS / envelope
    localparam int SCALE_TARGET  = 2000;
    localparam int SCALE_BITS    = 11;
    localparam int NUM_BITS      = SAMPLE_BITS + SCALE_BITS + FRAC_BITS;
    localparam logic [NUM_BITS-1:0] SCALE_NUM =
        NUM_BITS'(SCALE_TARGET * (1 << FRAC_BITS));
    localparam int QUO_BITS      = OUT_BITS + 1;
    localparam int REM_BITS      = ENV_BITS + OUT_BITS;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_CYCLES    = QUO_BITS / BITS_PER_STEP;
    localparam int CNT_BITS      = $clog2(DIV_CYCLES);

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_ENVELOPE_FLOOR = 1'b0;

    typedef struct packed {
        logic capture;
        logic gap;
        logic mul;
        logic update;
    } t_trk_ctrl;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
    } t_lane_ctrl;

    typedef struct packed {
        logic clear;
        logic update;
    } t_merge_ctrl;

endpackage

FILE: rtl/core/tenv_tracker.sv
// Envelope follower: channel maximum, attack/decay step and floor clamp.
// Depends on tenv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "trace_envelope_normalizer_macros.svh"

module tenv_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tenv_pkg::t_trk_ctrl              i_ctrl,
    input  logic                             i_new_trace,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0] i_sample [tenv_pkg::LANES],
    input  logic [tenv_pkg::FLOOR_BITS-1:0]  i_floor,
    output logic [tenv_pkg::ENV_BITS-1:0]    o_env_next
);

    logic [tenv_pkg::ENV_BITS-1:0]    r_envelope;
    logic [tenv_pkg::ENV_BITS-1:0]    r_target;
    logic                             r_new;
    logic                             r_load;
    logic                             r_attack;
    logic [tenv_pkg::OP_BITS-1:0]     r_operand;
    logic [tenv_pkg::Q_BITS-1:0]      r_quot;

    logic [tenv_pkg::SAMPLE_BITS-1:0] w_max_lo;
    logic [tenv_pkg::SAMPLE_BITS-1:0] w_max_hi;
    logic [tenv_pkg::SAMPLE_BITS-1:0] w_smax;
    logic                             w_attack;
    logic [tenv_pkg::ENV_BITS-1:0]    w_gap;
    logic [2*tenv_pkg::OP_BITS-1:0]   w_prod;
    logic [tenv_pkg::ENV_BITS-1:0]    w_env_calc;
    logic [tenv_pkg::FLOOR_BITS-1:0]  w_floor_int;
    logic [tenv_pkg::ENV_BITS-1:0]    w_floor_fx;

    // Largest of the four channels
    assign w_max_lo = (i_sample[0] >= i_sample[1]) ? i_sample[0] : i_sample[1];
    assign w_max_hi = (i_sample[2] >= i_sample[3]) ? i_sample[2] : i_sample[3];
    assign w_smax   = (w_max_lo >= w_max_hi) ? w_max_lo : w_max_hi;

    // Direction and size of the gap to the target
    assign w_attack = (r_target >= r_envelope);
    assign w_gap    = w_attack ? (r_target - r_envelope) : (r_envelope - r_target);

    // Divide by five through the reciprocal
    assign w_prod = {{tenv_pkg::OP_BITS{1'b0}}, r_operand}
                  * {{tenv_pkg::OP_BITS{1'b0}}, tenv_pkg::DIV5_MULT};

    // Apply the step, then clamp to the floor (a zero floor acts as one)
    assign w_env_calc  = r_load   ? r_target :
                         r_attack ? (r_envelope + tenv_pkg::ENV_BITS'(r_quot)) :
                                    (r_envelope - tenv_pkg::ENV_BITS'(r_quot));
    assign w_floor_int = (i_floor == '0) ? tenv_pkg::FLOOR_BITS'(1) : i_floor;
    assign w_floor_fx  = {w_floor_int, {tenv_pkg::FRAC_BITS{1'b0}}};
    assign o_env_next  = (w_env_calc < w_floor_fx) ? w_floor_fx : w_env_calc;

    // Hold the envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_envelope <= '0;
        end else if (i_ctrl.update) begin
            r_envelope <= o_env_next;
        end
    end

    // Advance the step pipeline
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_target <= {w_smax, {tenv_pkg::FRAC_BITS{1'b0}}};
            r_new    <= i_new_trace;
        end
        if (i_ctrl.gap) begin
            r_load   <= r_new || (r_envelope == '0);
            r_attack <= w_attack;
            r_operand <= w_attack ? tenv_pkg::OP_BITS'(w_gap >> tenv_pkg::ATTACK_SHIFT)
                                  : tenv_pkg::OP_BITS'(w_gap >> tenv_pkg::DECAY_SHIFT);
        end
        if (i_ctrl.mul) begin
            r_quot <= w_prod[2*tenv_pkg::OP_BITS-1:tenv_pkg::DIV5_SHIFT];
        end
    end

    `TEN_ASSERT_NEXT(a_env_above_floor, i_clk, i_rst_n, i_ctrl.update, r_envelope >= $past(w_floor_fx))

endmodule

FILE: rtl/core/tenv_lane.sv
// One scaling lane: sample * 2000 * 2^FRAC_BITS / envelope, four quotient
// bits per cycle, saturated to the output width. Depends on tenv_pkg.
`timescale 1ns / 1ps

module tenv_lane (
    input  logic                             i_clk,
    input  tenv_pkg::t_lane_ctrl             i_ctrl,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [tenv_pkg::ENV_BITS-1:0]    i_env,
    output logic [tenv_pkg::OUT_BITS-1:0]    o_scaled
);

    logic [tenv_pkg::REM_BITS-1:0] r_rem;
    logic [tenv_pkg::REM_BITS-1:0] r_dsr;
    logic [tenv_pkg::QUO_BITS-1:0] r_quo;
    logic [tenv_pkg::REM_BITS-1:0] n_rem;
    logic [tenv_pkg::REM_BITS-1:0] n_dsr;
    logic [tenv_pkg::QUO_BITS-1:0] n_quo;
    logic [tenv_pkg::NUM_BITS-1:0] w_num;

    // Scaled numerator
    assign w_num = tenv_pkg::NUM_BITS'(i_sample) * tenv_pkg::SCALE_NUM;

    // Restoring division, BITS_PER_STEP quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_dsr = r_dsr;
        n_quo = r_quo;
        for (int k = 0; k < tenv_pkg::BITS_PER_STEP; k++) begin
            if (n_rem >= n_dsr) begin
                n_rem = n_rem - n_dsr;
                n_quo = {n_quo[tenv_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[tenv_pkg::QUO_BITS-2:0], 1'b0};
            end
            n_dsr = n_dsr >> 1;
        end
    end

    // Load numerator, latch divisor, advance the quotient
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= tenv_pkg::REM_BITS'(w_num);
        end else if (i_ctrl.step) begin
            r_rem <= n_rem;
        end
        if (i_ctrl.start) begin
            r_dsr <= {i_env, {tenv_pkg::OUT_BITS{1'b0}}};
        end else if (i_ctrl.step) begin
            r_dsr <= n_dsr;
        end
        if (i_ctrl.step) begin
            r_quo <= n_quo;
        end
    end

    // Saturate when the quotient reaches the top bit
    assign o_scaled = r_quo[tenv_pkg::QUO_BITS-1] ? tenv_pkg::OUT_MAX
                                                  : r_quo[tenv_pkg::OUT_BITS-1:0];

endmodule

FILE: rtl/core/tenv_merge.sv
// Merging stage: largest scaled value across lanes folded into the
// per-trace running peak. Depends on tenv_pkg.
`timescale 1ns / 1ps

module tenv_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tenv_pkg::t_merge_ctrl         i_ctrl,
    input  logic [tenv_pkg::OUT_BITS-1:0] i_scaled [tenv_pkg::LANES],
    output logic [tenv_pkg::OUT_BITS-1:0] o_peak
);

    logic [tenv_pkg::OUT_BITS-1:0] r_peak;
    logic [tenv_pkg::OUT_BITS-1:0] w_lo;
    logic [tenv_pkg::OUT_BITS-1:0] w_hi;
    logic [tenv_pkg::OUT_BITS-1:0] w_lanes;

    // Compare tree over the lanes, then against the stored peak
    assign w_lo    = (i_scaled[0] >= i_scaled[1]) ? i_scaled[0] : i_scaled[1];
    assign w_hi    = (i_scaled[2] >= i_scaled[3]) ? i_scaled[2] : i_scaled[3];
    assign w_lanes = (w_lo >= w_hi) ? w_lo : w_hi;
    assign o_peak  = (w_lanes >= r_peak) ? w_lanes : r_peak;

    // Clear on a new trace, fold in when the point retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (i_ctrl.clear) begin
            r_peak <= '0;
        end else if (i_ctrl.update) begin
            r_peak <= o_peak;
        end
    end

endmodule

FILE: rtl/core/trace_envelope_normalizer.sv
// Top level of the trace envelope normalizer: sequencer, configuration
// register, output register. Depends on tenv_pkg, tenv_tracker, tenv_lane, tenv_merge.
`timescale 1ns / 1ps
`include "trace_envelope_normalizer_macros.svh"

// Each transfer carries one sample point of four channels (A, C, G, T) and
// returns one result: the four channels scaled by 2000 over a tracked
// envelope of the channel maximum (saturated at 32767) and the running peak
// of the trace. A point goes from its transfer to its result through the
// envelope step (gap, divide-by-five multiply, update with floor clamp),
// the four parallel lane dividers that each produce four quotient bits per
// cycle, and the merge of the peak with the load of the output register,
// which waits while a stalled result holds that register. A new point is
// accepted only in the idle state that follows; a finished result can wait
// in the output register while the next point is already in progress. The
// envelope floor register sits at byte address 0 and may be written only
// while the block is idle.
module trace_envelope_normalizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tenv_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tenv_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tenv_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_new_trace,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0]    i_sample_a,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0]    i_sample_c,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0]    i_sample_g,
    input  logic [tenv_pkg::SAMPLE_BITS-1:0]    i_sample_t,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tenv_pkg::OUT_BITS-1:0]       o_scaled_a,
    output logic [tenv_pkg::OUT_BITS-1:0]       o_scaled_c,
    output logic [tenv_pkg::OUT_BITS-1:0]       o_scaled_g,
    output logic [tenv_pkg::OUT_BITS-1:0]       o_scaled_t,
    output logic [tenv_pkg::OUT_BITS-1:0]       o_running_peak
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_MUL,
        S_ENV,
        S_DIV,
        S_FIN
    } t_state;

    localparam logic [tenv_pkg::CNT_BITS-1:0] CNT_LAST =
        tenv_pkg::CNT_BITS'(tenv_pkg::DIV_CYCLES - 1);

    t_state                            r_state;
    logic [tenv_pkg::CNT_BITS-1:0]     r_cnt;
    logic                              r_out_valid;
    logic [tenv_pkg::OUT_BITS-1:0]     r_scaled [tenv_pkg::LANES];
    logic [tenv_pkg::OUT_BITS-1:0]     r_peak_out;
    logic [tenv_pkg::FLOOR_BITS-1:0]   r_floor;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_fin_go;
    logic                              w_cfg_write;
    logic                              w_cfg_idx;
    logic [tenv_pkg::SAMPLE_BITS-1:0]  w_sample [tenv_pkg::LANES];
    logic [tenv_pkg::OUT_BITS-1:0]     w_scaled [tenv_pkg::LANES];
    logic [tenv_pkg::OUT_BITS-1:0]     w_peak;
    logic [tenv_pkg::ENV_BITS-1:0]     w_env_next;
    tenv_pkg::t_trk_ctrl               w_trk_ctrl;
    tenv_pkg::t_lane_ctrl              w_lane_ctrl;
    tenv_pkg::t_merge_ctrl             w_merge_ctrl;

    // Handshakes
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    // Configuration register
    assign pready      = 1'b1;
    assign w_cfg_idx   = paddr[tenv_pkg::APB_ADDR_BITS-1];
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (w_cfg_idx == tenv_pkg::REG_ENVELOPE_FLOOR)
                       ? {{(tenv_pkg::APB_DATA_BITS - tenv_pkg::FLOOR_BITS){1'b0}}, r_floor}
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= tenv_pkg::FLOOR_RESET;
        end else if (w_cfg_write && (w_cfg_idx == tenv_pkg::REG_ENVELOPE_FLOOR)) begin
            r_floor <= pwdata[tenv_pkg::FLOOR_BITS-1:0];
        end
    end

    // Unit controls
    assign w_trk_ctrl.capture  = w_accept;
    assign w_trk_ctrl.gap      = (r_state == S_GAP);
    assign w_trk_ctrl.mul      = (r_state == S_MUL);
    assign w_trk_ctrl.update   = (r_state == S_ENV);
    assign w_lane_ctrl.load    = w_accept;
    assign w_lane_ctrl.start   = (r_state == S_ENV);
    assign w_lane_ctrl.step    = (r_state == S_DIV);
    assign w_merge_ctrl.clear  = w_accept && i_new_trace;
    assign w_merge_ctrl.update = w_fin_go;

    assign w_sample[0] = i_sample_a;
    assign w_sample[1] = i_sample_c;
    assign w_sample[2] = i_sample_g;
    assign w_sample[3] = i_sample_t;

    tenv_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_trk_ctrl),
        .i_new_trace (i_new_trace),
        .i_sample    (w_sample),
        .i_floor     (r_floor),
        .o_env_next  (w_env_next)
    );

    for (genvar g = 0; g < tenv_pkg::LANES; g++) begin : g_lane
        tenv_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_lane_ctrl),
            .i_sample (w_sample[g]),
            .i_env    (w_env_next),
            .o_scaled (w_scaled[g])
        );
    end

    tenv_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_merge_ctrl),
        .i_scaled (w_scaled),
        .o_peak   (w_peak)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ENV;
                end
                S_ENV: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_fin_go) begin
                r_out_valid <= 1'b1;
                r_scaled    <= w_scaled;
                r_peak_out  <= w_peak;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scaled_a     = r_scaled[0];
    assign o_scaled_c     = r_scaled[1];
    assign o_scaled_g     = r_scaled[2];
    assign o_scaled_t     = r_scaled[3];
    assign o_running_peak = r_peak_out;

    `TEN_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, o_in_stall)
    `TEN_ASSERT_IMP(a_div_length, i_clk, i_rst_n, r_state == S_ENV, ##5 (r_state == S_FIN))
    `TEN_ASSERT_NEXT(a_fin_load, i_clk, i_rst_n, w_fin_go, o_out_valid && (o_running_peak >= $past(w_scaled[0])))

endmodule
